>>> sv/dwi_pkg.sv
package dwi_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths on the stream ports
    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    // Packed widths (tdata rounded up to whole bytes)
    localparam int S_TDATA_W = ((OP_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_ITERATE    = 3'd5,
        OP_ITER_RESET = 3'd6
    } t_op;

    // Per-word result flags, control to output stage
    typedef struct packed {
        logic rd_valid;
        logic overflow;
    } t_res_flags;

endpackage

>>> sv/dwi_mem.sv
module dwi_mem
    import dwi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = DATA_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/dwi_ctrl.sv
module dwi_ctrl
    import dwi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = DATA_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_op                i_op,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [WIDTH-1:0]   o_wr_data,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    output t_res_flags         o_flags,
    output logic [CW-1:0]      o_count
);

    localparam logic [CW:0]   DEPTH_S = (CW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);

    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_cursor, n_cursor;
    logic          r_active, n_active;

    logic [CW:0]   back_sum, last_sum;
    logic [AW-1:0] back_slot, last_slot;
    logic [AW-1:0] front_inc, front_dec, cursor_inc;
    logic [AW:0]   pos;
    logic          full, empty;

    // Ring arithmetic: every sum that is used stays below twice the depth
    always_comb begin
        back_sum  = (CW+1)'(r_front) + (CW+1)'(r_count);
        last_sum  = back_sum - (CW+1)'(1);
        back_slot = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
        last_slot = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);
        front_inc  = (r_front == LAST_IX) ? '0 : r_front + AW'(1);
        front_dec  = (r_front == '0) ? LAST_IX : r_front - AW'(1);
        cursor_inc = (r_cursor == LAST_IX) ? '0 : r_cursor + AW'(1);
        pos = (r_cursor >= r_front)
            ? (AW+1)'(r_cursor) - (AW+1)'(r_front)
            : (AW+1)'(r_cursor) + (AW+1)'(DEPTH) - (AW+1)'(r_front);
        full  = (r_count == DEPTH_C);
        empty = (r_count == '0);
    end

    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_active  = r_active;
        o_wr_en   = 1'b0;
        o_wr_addr = back_slot;
        o_wr_data = WIDTH'(i_value);
        o_rd_en   = 1'b0;
        o_rd_addr = r_front;
        o_flags   = '0;
        case (i_op)
            OP_PUSH_BACK: begin
                if (full) begin
                    o_flags.overflow = 1'b1;
                end else begin
                    o_wr_en = i_en;
                    n_count = r_count + CW'(1);
                end
            end
            OP_PUSH_FRONT: begin
                if (full) begin
                    o_flags.overflow = 1'b1;
                end else begin
                    n_front   = front_dec;
                    o_wr_en   = i_en;
                    o_wr_addr = front_dec;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_POP_BACK: begin
                if (!empty) begin
                    o_rd_en          = i_en;
                    o_rd_addr        = last_slot;
                    o_flags.rd_valid = 1'b1;
                    if (r_active && r_cursor == last_slot) begin
                        n_active = 1'b0;
                    end
                    n_count = r_count - CW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (!empty) begin
                    o_rd_en          = i_en;
                    o_flags.rd_valid = 1'b1;
                    if (r_active && r_cursor == r_front) begin
                        n_active = 1'b0;
                    end
                    n_front = front_inc;
                    n_count = r_count - CW'(1);
                end
            end
            OP_PEEK_FRONT: begin
                if (!empty) begin
                    o_rd_en          = i_en;
                    o_flags.rd_valid = 1'b1;
                end
            end
            OP_ITERATE: begin
                if (!r_active) begin
                    if (!empty) begin
                        n_cursor         = r_front;
                        n_active         = 1'b1;
                        o_rd_en          = i_en;
                        o_flags.rd_valid = 1'b1;
                    end
                end else if ((CW+1)'(pos) + (CW+1)'(1) < (CW+1)'(r_count)) begin
                    n_cursor         = cursor_inc;
                    o_rd_en          = i_en;
                    o_rd_addr        = cursor_inc;
                    o_flags.rd_valid = 1'b1;
                end else begin
                    n_active = 1'b0;
                end
            end
            OP_ITER_RESET: begin
                n_active = 1'b0;
                n_cursor = '0;
            end
            default: begin
            end
        endcase
        o_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_cursor <= '0;
            r_active <= 1'b0;
        end else if (i_en) begin
            r_front  <= n_front;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_active <= n_active;
        end
    end

endmodule

>>> sv/deque_with_iterator.sv
// Bounded double-ended queue of DEPTH words in a ring buffer, with a forward
// iterator. Each input word carries one operation (push back/front, pop
// back/front, peek front, iterate, reset iterator) and produces exactly one
// output word: the data removed, peeked or iterated (zero when not valid), a
// valid flag, the entry count after the operation and an overflow flag for a
// push into a full store (the pushed word is dropped). Iteration starts at the
// front, walks toward the back, returns one invalid word after the back and
// then starts over; popping the entry under the iterator clears it. The output
// word is valid in the cycle after the accept, and one operation is taken
// every cycle while the output is not stalled: index updates and the store
// write or read all happen at the accept edge, and the store's registered
// read port feeds the output stage directly. The store needs no clearing pass
// after reset. The count field is the low 7 bits of the internal count.
module deque_with_iterator
    import dwi_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // operation[2:0], value[34:3], zero pad
    // master side
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // data[31:0], count[38:32], zero pad
    output logic [M_TUSER_W-1:0] o_m_tuser   // data_valid[0], overflow[1]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // stored word width: value is kept at DATA_WIDTH bits, never more than the field
    localparam int SW = (DATA_WIDTH < DATA_W) ? DATA_WIDTH : DATA_W;

    logic               accept;
    t_op                op;
    logic [VALUE_W-1:0] value;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [SW-1:0] wr_data, rd_data;
    t_res_flags    flags;
    logic [CW-1:0] count_next;

    // output stage; data word itself sits in the store's read register
    logic               r_ovalid;
    t_res_flags         r_flags;
    logic [COUNT_W-1:0] r_count;
    logic [DATA_W-1:0]  out_data;

    assign o_s_tready = !r_ovalid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign op         = t_op'(i_s_tdata[OP_W-1:0]);
    assign value      = i_s_tdata[OP_W+VALUE_W-1:OP_W];

    dwi_ctrl #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (accept),
        .i_op      (op),
        .i_value   (value),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_flags   (flags),
        .o_count   (count_next)
    );

    // read register only loads on accept, so it holds while the output stalls
    dwi_mem #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (accept) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flags <= flags;
            r_count <= COUNT_W'(count_next);
        end
    end

    // invalid results read as zero
    assign out_data   = r_flags.rd_valid ? DATA_W'(rd_data) : '0;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = M_TDATA_W'({r_count, out_data});
    assign o_m_tuser  = {r_flags.overflow, r_flags.rd_valid};

    // ---------------------------------------------------------------- checks
    a_accept_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_m_tvalid)
        else $error("accepted word produced no output word");

    a_overflow_not_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> !o_m_tuser[0])
        else $error("overflow word flagged as holding data");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[DATA_W-1:0] == '0)
        else $error("invalid output word carries nonzero data");

endmodule

>>> dv/deque_with_iterator_tb.sv
module deque_with_iterator_tb
    import dwi_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RAND_WORDS   = 260;            // per idling phase, four phases

    // Operation code outside the enum: the block must ignore it.
    localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd7;

    // One result word, unpacked from tdata/tuser.
    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } t_deque_result;

    // One row of the directed table. A row may repeat; repeated rows draw
    // random values. 'typed' rows carry their own expected word.
    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        int                 reps;
        bit                 typed;
        t_deque_result      want;
    } t_stim_row;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;

    deque_with_iterator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // operation[2:0], value[34:3], zero pad
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // data[31:0], count[38:32], zero pad
        .o_m_tuser  (o_m_tuser)    // data_valid[0], overflow[1]
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Deque mirror: ring of DEPTH words, front index, count and cursor.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] ring_words [DEPTH];
    int                front_idx;
    int                entry_cnt;
    int                cursor_idx;
    bit                cursor_on;

    t_deque_result     expected_results [$];
    bit                failed;
    int                send_idle_pct;
    int                stall_pct;
    int unsigned       cycle_cnt;
    t_deque_result     head;
    t_stim_row         directed_rows [$];

    // Applies one operation to the mirror and returns the word the block
    // should send back for it.
    function automatic t_deque_result apply_deque_op(input logic [OP_W-1:0]    op,
                                                     input logic [VALUE_W-1:0] value);
        t_deque_result r;
        int            slot;
        int            pos;
        r = '0;
        case (op)
            OP_PUSH_BACK: begin
                if (entry_cnt >= DEPTH) begin
                    r.overflow = 1'b1;         // full: word dropped
                end else begin
                    ring_words[(front_idx + entry_cnt) % DEPTH] = value[DATA_W-1:0];
                    entry_cnt++;
                end
            end
            OP_PUSH_FRONT: begin
                if (entry_cnt >= DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    front_idx = (front_idx + DEPTH - 1) % DEPTH;
                    ring_words[front_idx] = value[DATA_W-1:0];
                    entry_cnt++;
                end
            end
            OP_POP_BACK: begin
                if (entry_cnt > 0) begin
                    slot    = (front_idx + entry_cnt - 1) % DEPTH;
                    r.data  = ring_words[slot];
                    r.valid = 1'b1;
                    if (cursor_on && cursor_idx == slot) cursor_on = 1'b0;
                    entry_cnt--;
                end
            end
            OP_POP_FRONT: begin
                if (entry_cnt > 0) begin
                    r.data  = ring_words[front_idx];
                    r.valid = 1'b1;
                    if (cursor_on && cursor_idx == front_idx) cursor_on = 1'b0;
                    front_idx = (front_idx + 1) % DEPTH;
                    entry_cnt--;
                end
            end
            OP_PEEK_FRONT: begin
                if (entry_cnt > 0) begin
                    r.data  = ring_words[front_idx];
                    r.valid = 1'b1;
                end
            end
            OP_ITERATE: begin
                if (!cursor_on) begin
                    // first step lands on the front
                    if (entry_cnt > 0) begin
                        cursor_idx = front_idx;
                        cursor_on  = 1'b1;
                        r.data     = ring_words[cursor_idx];
                        r.valid    = 1'b1;
                    end
                end else begin
                    pos = (cursor_idx + DEPTH - front_idx) % DEPTH;
                    if (pos + 1 < entry_cnt) begin
                        cursor_idx = (cursor_idx + 1) % DEPTH;
                        r.data     = ring_words[cursor_idx];
                        r.valid    = 1'b1;
                    end else begin
                        cursor_on = 1'b0;      // past the back: one null word
                    end
                end
            end
            OP_ITER_RESET: begin
                cursor_on  = 1'b0;
                cursor_idx = 0;
            end
            default: ;                         // unknown op: no change
        endcase
        r.count = entry_cnt[COUNT_W-1:0];
        return r;
    endfunction

    // Offers one word on the slave side after a random gap; the expected
    // result is queued at the accept edge.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                             input bit typed, input t_deque_result want);
        t_deque_result got;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_TDATA_W - OP_W - VALUE_W){1'b0}}, value, op};
        do @(posedge i_clk); while (!o_s_tready);
        got = apply_deque_op(op, value);
        expected_results.push_back(typed ? want : got);
        @(negedge i_clk);
    endtask

    function automatic void add_row(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                                    input int reps, input bit typed,
                                    input logic [DATA_W-1:0] data, input logic valid,
                                    input int count, input logic overflow);
        t_stim_row row;
        row.op   = op;
        row.value = value;
        row.reps = reps;
        row.typed = typed;
        row.want = '{data: data, valid: valid, count: count[COUNT_W-1:0], overflow: overflow};
        directed_rows.push_back(row);
    endfunction

    // Mixed traffic that sweeps the fill level between empty and full: a
    // trend flag biases pushes against pops and flips at the ends.
    task automatic run_random(input int n);
        bit              filling;
        int              pick;
        logic [OP_W-1:0] op;
        filling = (entry_cnt < DEPTH / 2);
        for (int i = 0; i < n; i++) begin
            if (entry_cnt == 0) filling = 1'b1;
            if (entry_cnt >= DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
            if ($urandom_range(0, 199) == 0) filling = !filling;
            pick = $urandom_range(0, 99);
            if (pick < 1)
                op = OP_UNKNOWN;
            else if (pick < 4)
                op = OP_ITER_RESET;
            else if (pick < 24)
                op = OP_ITERATE;
            else if (pick < 30)
                op = OP_PEEK_FRONT;
            else if ($urandom_range(0, 99) < (filling ? 75 : 25))
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            send_word(op, $urandom(), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, set at the falling edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Compare each accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: tdata %h tuser %h",
                       o_m_tdata, o_m_tuser);
                failed = 1'b1;
            end else begin
                head = expected_results.pop_front();
                if (o_m_tdata[DATA_W-1:0] !== head.data) begin
                    $error("data: expected %h, actual %h", head.data, o_m_tdata[DATA_W-1:0]);
                    failed = 1'b1;
                end
                if (o_m_tuser[0] !== head.valid) begin
                    $error("data_valid: expected %0d, actual %0d", head.valid, o_m_tuser[0]);
                    failed = 1'b1;
                end
                if (o_m_tdata[DATA_W +: COUNT_W] !== head.count) begin
                    $error("count: expected %0d, actual %0d", head.count,
                           o_m_tdata[DATA_W +: COUNT_W]);
                    failed = 1'b1;
                end
                if (o_m_tuser[1] !== head.overflow) begin
                    $error("overflow: expected %0d, actual %0d", head.overflow, o_m_tuser[1]);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        failed        = 1'b0;
        cycle_cnt     = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        front_idx     = 0;
        entry_cnt     = 0;
        cursor_idx    = 0;
        cursor_on     = 1'b0;

        // Directed table. Empty store first: every read-type op gives a null
        // word, and the unknown op does nothing.
        add_row(OP_PEEK_FRONT, 32'h0, 1, 1, 32'h0, 0, 0, 0);
        add_row(OP_POP_BACK,   32'h0, 1, 1, 32'h0, 0, 0, 0);
        add_row(OP_POP_FRONT,  32'h0, 1, 1, 32'h0, 0, 0, 0);
        add_row(OP_ITERATE,    32'h0, 1, 1, 32'h0, 0, 0, 0);
        add_row(OP_UNKNOWN,    32'hFFFF_FFFF, 1, 1, 32'h0, 0, 0, 0);
        add_row(OP_ITER_RESET, 32'h0, 1, 1, 32'h0, 0, 0, 0);
        // Two entries, all-ones at the back, zero at the front.
        add_row(OP_PUSH_BACK,  32'hFFFF_FFFF, 1, 1, 32'h0, 0, 1, 0);
        add_row(OP_PUSH_FRONT, 32'h0, 1, 1, 32'h0, 0, 2, 0);
        add_row(OP_PEEK_FRONT, 32'h0, 1, 1, 32'h0, 1, 2, 0);
        // Walk: front, back, then one null word past the back.
        add_row(OP_ITERATE,    32'h0, 1, 1, 32'h0, 1, 2, 0);
        add_row(OP_ITERATE,    32'h0, 1, 1, 32'hFFFF_FFFF, 1, 2, 0);
        add_row(OP_ITERATE,    32'h0, 1, 1, 32'h0, 0, 2, 0);
        add_row(OP_ITERATE,    32'h0, 1, 0, 32'h0, 0, 0, 0);
        add_row(OP_ITER_RESET, 32'h0, 1, 1, 32'h0, 0, 2, 0);
        add_row(OP_ITERATE,    32'h0, 1, 0, 32'h0, 0, 0, 0);
        // Pop the entry under the cursor: next step restarts at the front.
        add_row(OP_POP_FRONT,  32'h0, 1, 1, 32'h0, 1, 1, 0);
        add_row(OP_ITERATE,    32'h0, 1, 0, 32'h0, 0, 0, 0);
        add_row(OP_POP_BACK,   32'h0, 1, 1, 32'hFFFF_FFFF, 1, 0, 0);
        // Same from the back end.
        add_row(OP_PUSH_BACK,  32'hA5A5_5A5A, 1, 0, 32'h0, 0, 0, 0);
        add_row(OP_ITERATE,    32'h0, 1, 0, 32'h0, 0, 0, 0);
        add_row(OP_POP_BACK,   32'h0, 1, 1, 32'hA5A5_5A5A, 1, 0, 0);
        add_row(OP_ITERATE,    32'h0, 1, 1, 32'h0, 0, 0, 0);
        // Fill from both ends, then push into the full store.
        add_row(OP_PUSH_BACK,  32'h0, DEPTH / 2, 0, 32'h0, 0, 0, 0);
        add_row(OP_PUSH_FRONT, 32'h0, DEPTH / 2, 0, 32'h0, 0, 0, 0);
        add_row(OP_PUSH_BACK,  32'h0, 1, 1, 32'h0, 0, DEPTH, 1);
        add_row(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1, 32'h0, 0, DEPTH, 1);
        // Full walk across the wrap point, then a few removals.
        add_row(OP_ITERATE,    32'h0, DEPTH + 3, 0, 32'h0, 0, 0, 0);
        add_row(OP_POP_BACK,   32'h0, 2, 0, 32'h0, 0, 0, 0);
        add_row(OP_POP_FRONT,  32'h0, 2, 0, 32'h0, 0, 0, 0);
        add_row(OP_PEEK_FRONT, 32'h0, 1, 0, 32'h0, 0, 0, 0);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 19;
        stall_pct     = 19;
        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                send_word(directed_rows[r].op,
                          (directed_rows[r].reps > 1) ? $urandom() : directed_rows[r].value,
                          directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // Random traffic under each idling mix: none, sender gaps, receiver
        // stalls, both.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 84; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 84; end
                default: begin send_idle_pct = 19; stall_pct = 19; end
            endcase
            run_random(RAND_WORDS);
        end
        i_s_tvalid <= 1'b0;

        // Drain, then a few cycles for any stray word.
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (!failed)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
